// ===== rtl/dlr_pkg.sv =====
// Shared types and codes of the drag line rasterizer.
package dlr_pkg;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_PRESS = 2'd0,
    CMD_DRAG  = 2'd1,
    CMD_CONT  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // Operations handed from the front to the walker.
  typedef enum logic [1:0] {
    OP_PRESS = 2'd0,
    OP_DRAG  = 2'd1,
    OP_CONT  = 2'd2
  } op_e;

  // Walker states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_e;

  // Flags that travel with every pixel.
  typedef struct packed {
    logic last;
    logic pending;
  } px_flags_t;

endpackage

// ===== rtl/dlr_fifo.sv =====
// Small first-in first-out queue built from registers.
module dlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == NW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dlr_front.sv =====
// Front end: takes input items and classifies them into walker operations.
module dlr_front (
  input  logic          push_i,
  input  logic [1:0]    cmd_i,
  input  logic          op_full_i,
  output logic          full_o,
  output logic          op_push_o,
  output dlr_pkg::op_e  op_kind_o
);

  import dlr_pkg::*;

  cmd_e cmd;
  logic accept;
  logic keep;

  assign cmd    = cmd_e'(cmd_i);
  assign full_o = op_full_i;
  assign accept = push_i && !op_full_i;

  // Unused command codes are taken and dropped here.
  always_comb begin
    keep      = 1'b1;
    op_kind_o = OP_PRESS;
    unique case (cmd)
      CMD_PRESS: op_kind_o = OP_PRESS;
      CMD_DRAG:  op_kind_o = OP_DRAG;
      CMD_CONT:  op_kind_o = OP_CONT;
      CMD_RSVD:  keep      = 1'b0;
    endcase
  end

  assign op_push_o = accept && keep;

endmodule

// ===== rtl/dlr_back.sv =====
// Back end: keeps the anchor and walks the stair-step line one pixel a cycle while the pixel queue has room.
module dlr_back #(
  parameter int COORD_BITS = 10,
  parameter int CHUNK      = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  dlr_pkg::op_e          op_kind_i,
  input  logic [COORD_BITS-1:0] op_x_i,
  input  logic [COORD_BITS-1:0] op_y_i,
  output logic                  op_pop_o,
  input  logic                  px_full_i,
  output logic                  px_push_o,
  output logic [COORD_BITS-1:0] px_x_o,
  output logic [COORD_BITS-1:0] px_y_o,
  output dlr_pkg::px_flags_t    px_flags_o
);

  import dlr_pkg::*;

  localparam int EW = COORD_BITS + 2;
  localparam int CW = $clog2(CHUNK + 1);

  back_state_e            state_q, state_d;
  logic [COORD_BITS-1:0]  anchor_x_q, anchor_x_d, anchor_y_q, anchor_y_d;
  logic                   anchor_valid_q, anchor_valid_d;
  logic [COORD_BITS-1:0]  xstop_q, xstop_d, ystop_q, ystop_d;
  logic [COORD_BITS-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic                   neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic                   mode_y_q, mode_y_d;
  logic signed [EW-1:0]   err_q, err_d;
  logic                   active_q, active_d;
  logic                   first_q, first_d;
  logic [CW-1:0]          cnt_q, cnt_d;

  logic                   take_op;
  logic                   is_point;
  logic                   ld_neg_x, ld_neg_y;
  logic [COORD_BITS-1:0]  ld_dx, ld_dy;
  logic signed [EW-1:0]   dx_ext, dy_ext;
  logic                   step_x;
  logic [COORD_BITS-1:0]  post_x, post_y;
  logic signed [EW-1:0]   err_post;
  logic                   has_more;
  logic [CW-1:0]          cnt_inc;
  logic                   more;

  assign take_op  = (state_q == BK_IDLE) && op_valid_i && !px_full_i;
  assign is_point = (op_kind_i == OP_PRESS) ||
                    ((op_kind_i == OP_DRAG) &&
                     (!anchor_valid_q || (op_x_i == anchor_x_q && op_y_i == anchor_y_q)));

  // Segment setup from the anchor toward the new target.
  assign ld_neg_x = anchor_x_q > op_x_i;
  assign ld_neg_y = anchor_y_q > op_y_i;
  assign ld_dx    = ld_neg_x ? anchor_x_q - op_x_i : op_x_i - anchor_x_q;
  assign ld_dy    = ld_neg_y ? anchor_y_q - op_y_i : op_y_i - anchor_y_q;

  // One walk step. The first pixel of a drag is the anchor itself.
  assign dx_ext = signed'({2'b00, dx_q});
  assign dy_ext = signed'({2'b00, dy_q});
  assign step_x = !first_q && !mode_y_q && err_q[EW-1];

  always_comb begin
    post_x   = anchor_x_q;
    post_y   = anchor_y_q;
    err_post = err_q;
    if (!first_q) begin
      if (step_x) begin
        post_x   = neg_x_q ? anchor_x_q - COORD_BITS'(1) : anchor_x_q + COORD_BITS'(1);
        err_post = err_q + dy_ext;
      end else begin
        post_y = neg_y_q ? anchor_y_q - COORD_BITS'(1) : anchor_y_q + COORD_BITS'(1);
        if (!mode_y_q) begin
          err_post = err_q - dx_ext;
        end
      end
    end
  end

  // The stop marks sit one step short of the target, which is never drawn.
  assign has_more = mode_y_q ? (post_y != ystop_q)
                             : (!err_post[EW-1] || (post_x != xstop_q));
  assign cnt_inc  = cnt_q + CW'(1);
  assign more     = (cnt_inc < CW'(CHUNK)) && has_more;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take_op) begin
          if (op_kind_i == OP_DRAG && !is_point) begin
            state_d = BK_WALK;
          end else if (op_kind_i == OP_CONT && active_q) begin
            state_d = BK_WALK;
          end
        end
      end
      BK_WALK: begin
        if (!px_full_i && !more) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    op_pop_o       = take_op;
    px_push_o      = 1'b0;
    px_x_o         = op_x_i;
    px_y_o         = op_y_i;
    px_flags_o     = '{last: 1'b1, pending: 1'b0};
    anchor_x_d     = anchor_x_q;
    anchor_y_d     = anchor_y_q;
    anchor_valid_d = anchor_valid_q;
    xstop_d        = xstop_q;
    ystop_d        = ystop_q;
    dx_d           = dx_q;
    dy_d           = dy_q;
    neg_x_d        = neg_x_q;
    neg_y_d        = neg_y_q;
    mode_y_d       = mode_y_q;
    err_d          = err_q;
    active_d       = active_q;
    first_d        = first_q;
    cnt_d          = cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take_op) begin
          if (is_point) begin
            px_push_o      = 1'b1;
            anchor_x_d     = op_x_i;
            anchor_y_d     = op_y_i;
            anchor_valid_d = 1'b1;
            active_d       = 1'b0;
          end else if (op_kind_i == OP_DRAG) begin
            xstop_d  = ld_neg_x ? op_x_i + COORD_BITS'(1) : op_x_i - COORD_BITS'(1);
            ystop_d  = ld_neg_y ? op_y_i + COORD_BITS'(1) : op_y_i - COORD_BITS'(1);
            dx_d     = ld_dx;
            dy_d     = ld_dy;
            neg_x_d  = ld_neg_x;
            neg_y_d  = ld_neg_y;
            mode_y_d = (ld_dx == '0);
            err_d    = (ld_dx == '0) ? '0
                                     : signed'({2'b00, ld_dy}) - signed'({2'b00, ld_dx});
            active_d = 1'b1;
            first_d  = 1'b1;
            cnt_d    = '0;
          end else if (op_kind_i == OP_CONT && active_q) begin
            first_d = 1'b0;
            cnt_d   = '0;
          end
        end
      end
      BK_WALK: begin
        px_x_o     = post_x;
        px_y_o     = post_y;
        px_flags_o = '{last: !more, pending: !more && has_more};
        if (!px_full_i) begin
          px_push_o  = 1'b1;
          anchor_x_d = post_x;
          anchor_y_d = post_y;
          err_d      = err_post;
          first_d    = 1'b0;
          cnt_d      = cnt_inc;
          if (!more) begin
            active_d = has_more;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      anchor_x_q     <= '0;
      anchor_y_q     <= '0;
      anchor_valid_q <= 1'b0;
      active_q       <= 1'b0;
      first_q        <= 1'b0;
      cnt_q          <= '0;
    end else begin
      state_q        <= state_d;
      anchor_x_q     <= anchor_x_d;
      anchor_y_q     <= anchor_y_d;
      anchor_valid_q <= anchor_valid_d;
      active_q       <= active_d;
      first_q        <= first_d;
      cnt_q          <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xstop_q  <= xstop_d;
    ystop_q  <= ystop_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    mode_y_q <= mode_y_d;
    err_q    <= err_d;
  end

endmodule

// ===== rtl/drag_line_rasterizer_top.sv =====
// Top level of the drag line rasterizer: front, operation queue, walker, pixel queue.
//
// Usage. Pointer events enter as items on a queue-style port: an item is taken at a
// rising edge of clk_i where push is high and full is low. cmd_i selects press (0),
// drag (1) or continue (2); code 3 is taken and dropped without any pixel. Pixels
// leave on a second queue-style port: the oldest pixel sits on pixel_x_o/pixel_y_o
// while empty is low and is taken at an edge where pop is high. last_of_run_o marks
// the final pixel an item produces; segment_pending_o on that pixel asks for a
// continue item to fetch the rest of a long line.
// A press pixel passes through the operation queue and then the pixel queue; the
// first pixel of a drag also waits while the walker loads the line in its idle state.
// Throughput: the walker emits one pixel per cycle while the pixel queue has room. A
// drag or continue item takes a setup step first and then gives at most CHUNK pixels.
// A two-entry queue of operations sits between front and walker, so the front keeps
// taking items while the walker is busy; full rises once that queue is filled.
// When the receiver stops popping, the two-entry pixel queue fills, the walker holds
// its place in the line, and no pixel is lost. Reset clears both queues, forgets the
// anchor and abandons any line in progress; no memory needs a clearing pass.
module drag_line_rasterizer_top #(
  parameter int COORD_BITS = 10,
  parameter int CHUNK      = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            cmd_i,
  input  logic [COORD_BITS-1:0] x_coord_i,
  input  logic [COORD_BITS-1:0] y_coord_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_of_run_o,
  output logic                  segment_pending_o
);

  import dlr_pkg::*;

  localparam int OP_W = $bits(op_e) + 2 * COORD_BITS;
  localparam int PX_W = 2 * COORD_BITS + $bits(px_flags_t);

  // Front to operation queue.
  logic            op_push;
  op_e             op_kind_in;
  logic            op_full;
  logic [OP_W-1:0] op_wdata, op_rdata;

  // Operation queue to walker.
  logic                  op_empty;
  logic                  op_pop;
  op_e                   op_kind;
  logic [COORD_BITS-1:0] op_x, op_y;

  // Walker to pixel queue.
  logic                  px_push;
  logic                  px_full;
  logic [COORD_BITS-1:0] px_x, px_y;
  px_flags_t             px_flags, out_flags;
  logic [PX_W-1:0]       px_wdata, px_rdata;

  dlr_front u_front (
    .push_i    (push),
    .cmd_i     (cmd_i),
    .op_full_i (op_full),
    .full_o    (full),
    .op_push_o (op_push),
    .op_kind_o (op_kind_in)
  );

  assign op_wdata = {op_kind_in, x_coord_i, y_coord_i};

  dlr_fifo #(
    .WIDTH (OP_W),
    .DEPTH (2)
  ) u_op_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (op_push),
    .push_data_i (op_wdata),
    .full_o      (op_full),
    .pop_i       (op_pop),
    .pop_data_o  (op_rdata),
    .empty_o     (op_empty)
  );

  assign op_kind = op_e'(op_rdata[OP_W-1 -: $bits(op_e)]);
  assign op_x    = op_rdata[2*COORD_BITS-1 -: COORD_BITS];
  assign op_y    = op_rdata[COORD_BITS-1:0];

  dlr_back #(
    .COORD_BITS (COORD_BITS),
    .CHUNK      (CHUNK)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!op_empty),
    .op_kind_i  (op_kind),
    .op_x_i     (op_x),
    .op_y_i     (op_y),
    .op_pop_o   (op_pop),
    .px_full_i  (px_full),
    .px_push_o  (px_push),
    .px_x_o     (px_x),
    .px_y_o     (px_y),
    .px_flags_o (px_flags)
  );

  assign px_wdata = {px_x, px_y, px_flags};

  dlr_fifo #(
    .WIDTH (PX_W),
    .DEPTH (2)
  ) u_px_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (px_push),
    .push_data_i (px_wdata),
    .full_o      (px_full),
    .pop_i       (pop),
    .pop_data_o  (px_rdata),
    .empty_o     (empty)
  );

  assign pixel_x_o         = px_rdata[PX_W-1 -: COORD_BITS];
  assign pixel_y_o         = px_rdata[PX_W-COORD_BITS-1 -: COORD_BITS];
  assign out_flags         = px_flags_t'(px_rdata[$bits(px_flags_t)-1:0]);
  assign last_of_run_o     = out_flags.last;
  assign segment_pending_o = out_flags.pending;

  // The walker only pushes a pixel when the pixel queue has room.
  a_px_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_push |-> !px_full)
    else $error("pixel pushed into a full pixel queue");

  // The walker only takes an operation that is waiting.
  a_op_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> !op_empty)
    else $error("operation taken from an empty queue");

  // A pending continue request only rides on the final pixel of an item.
  a_pending_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && segment_pending_o) |-> last_of_run_o)
    else $error("segment pending flagged on a pixel that is not the last");

endmodule
